// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fbfl_pkg.sv =====
// Package: widths, operation and status codes of the fixed-block free list.
`timescale 1ns / 1ps

package fbfl_pkg;

    localparam int NUM_BLOCKS_DEF = 256;

    localparam int IDX_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_ALLOC    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_NULL     = 2'd3;

endpackage

// ===== design/fbfl_ram.sv =====
// Generic single-clock RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module fbfl_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/fixed_block_free_list_unit.sv =====
// Fixed-block free list: LIFO pool allocator of NUM_BLOCKS equal-size blocks.
// After reset an init pass writes the link memory (entry i links to i + 1), one entry per
// cycle; no beat is accepted until it ends. Then an allocate passes through ST_POP, where
// the link of the head block, read from the registered link memory, becomes the new head
// while the input stalls. A release, a null release and an allocate on an empty pool
// stay in ST_RUN. Every beat gives one result beat, held in an output register, so a
// new beat is taken while the previous result waits as long as that register frees up.
`timescale 1ns / 1ps

module fixed_block_free_list_unit #(
    parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [fbfl_pkg::IDX_W-1:0]    i_block_index,
    input  logic                          i_null_ref,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [fbfl_pkg::IDX_W-1:0]    o_granted_index,
    output logic [fbfl_pkg::STATUS_W-1:0] o_status
);

    localparam int AW    = $clog2(NUM_BLOCKS);
    localparam int HW    = $clog2(NUM_BLOCKS + 1);
    localparam int EXT_W = (HW > fbfl_pkg::IDX_W) ? HW : fbfl_pkg::IDX_W;
    localparam int XW    = (AW > fbfl_pkg::IDX_W) ? AW : fbfl_pkg::IDX_W;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_RUN,
        ST_POP
    } t_state;

    t_state                        r_state;
    logic [AW-1:0]                 r_init_cnt;
    logic [HW-1:0]                 r_head;
    logic                          r_out_valid;
    logic [fbfl_pkg::IDX_W-1:0]    r_granted;
    logic [fbfl_pkg::STATUS_W-1:0] r_status;

    logic          accept;
    logic          empty;
    logic          rel_ok;
    logic [EXT_W-1:0] head_ext;
    logic [XW-1:0] idx_ext;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [HW-1:0] ram_wdata;
    logic          ram_re;
    logic [HW-1:0] ram_rdata;

    assign accept   = i_in_valid && !o_in_stall;
    assign empty    = (r_head == HW'(NUM_BLOCKS));
    assign rel_ok   = !i_null_ref && (32'(i_block_index) < 32'(NUM_BLOCKS));
    assign head_ext = EXT_W'(r_head);
    assign idx_ext  = XW'(i_block_index);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_init_cnt;
        ram_wdata = HW'(r_init_cnt) + HW'(1);
        if (r_state == ST_INIT) begin
            ram_we = 1'b1;
        end else if (accept && i_func == fbfl_pkg::FUNC_RELEASE && rel_ok) begin
            ram_we    = 1'b1;
            ram_waddr = idx_ext[AW-1:0];
            ram_wdata = r_head;
        end
    end

    assign ram_re = accept && i_func == fbfl_pkg::FUNC_ALLOC && !empty;

    fbfl_ram #(
        .WIDTH (HW),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_head[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_init_cnt  <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_INIT: begin
                    r_init_cnt <= r_init_cnt + AW'(1);
                    if (r_init_cnt == AW'(NUM_BLOCKS - 1)) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (accept) begin
                        if (i_func == fbfl_pkg::FUNC_ALLOC) begin
                            if (!empty) begin
                                r_state <= ST_POP;
                            end
                        end else if (rel_ok) begin
                            r_head <= HW'(i_block_index);
                        end
                    end
                end
                ST_POP: begin
                    r_head  <= ram_rdata;
                    r_state <= ST_RUN;
                end
                default: r_state <= ST_INIT;
            endcase

            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        if (accept) begin
            r_granted <= '0;
            if (i_func == fbfl_pkg::FUNC_ALLOC) begin
                if (empty) begin
                    r_status <= fbfl_pkg::STAT_EMPTY;
                end else begin
                    r_status  <= fbfl_pkg::STAT_ALLOC;
                    r_granted <= head_ext[fbfl_pkg::IDX_W-1:0];
                end
            end else begin
                r_status <= rel_ok ? fbfl_pkg::STAT_RELEASED : fbfl_pkg::STAT_NULL;
            end
        end
    end

    assign o_in_stall      = (r_state != ST_RUN) || (r_out_valid && i_out_stall);
    assign o_out_valid     = r_out_valid;
    assign o_granted_index = r_granted;
    assign o_status        = r_status;

endmodule

// ===== design/fbfl_checker.sv =====
// Port-level checker for the fixed-block free list, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fbfl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          i_func,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [fbfl_pkg::IDX_W-1:0]    o_granted_index,
    input logic [fbfl_pkg::STATUS_W-1:0] o_status
);

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> o_in_stall && !o_out_valid, "busy after reset")
    `ASSERT_CLK(a_result_follows, i_clk, i_rst_n, in_beat |=> o_out_valid, "no result beat")
    `ASSERT_CLK(a_grant_blocks, i_clk, i_rst_n, in_beat && i_func == fbfl_pkg::FUNC_ALLOC |=> o_status != fbfl_pkg::STAT_ALLOC || o_in_stall, "pop not interlocked")
    `ASSERT_CLK(a_grant_zero, i_clk, i_rst_n, o_out_valid && o_status != fbfl_pkg::STAT_ALLOC |-> o_granted_index == '0, "index on non-grant")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_granted_index), "stalled result moved")

endmodule

bind fixed_block_free_list_unit fbfl_checker u_fbfl_checker (.*);
